// ===== design/chm_pkg.sv =====
`timescale 1ns / 1ps
package chm_pkg;
  localparam int BUCKETS_DEF = 16;
  localparam int ENTRIES_DEF = 1024;
  localparam int KEY_BITS_DEF = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_SET    = 3'd3,
    OP_SWAP   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXISTS    = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] second_key;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] value_out;
  } result_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
    logic hit;
  } walk_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_LOOK1,
    S_LOOK2,
    S_ACT,
    S_RD_FREE,
    S_RD_FREE_W,
    S_DEL_RD,
    S_DEL_RD_W,
    S_DEL_LINK,
    S_SWAP_RD,
    S_SWAP_RD_W,
    S_SWAP_WR,
    S_OUT
  } state_t;
endpackage

// ===== design/chm_walker.sv =====
`timescale 1ns / 1ps
module chm_walker import chm_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  localparam int PW = $clog2(ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [PW-1:0]       head,
  input  logic [KEY_BITS-1:0] target,
  output logic [PW-1:0]       rd_addr,
  output logic                rd_en,
  input  logic [KEY_BITS-1:0] rd_key,
  input  logic [PW-1:0]       rd_next,
  output walk_ctl_t           ctl,
  output logic [PW-1:0]       node,
  output logic [PW-1:0]       prev
);
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  logic          busy, wait_rd, done, hit;
  logic [PW-1:0] cur;

  assign rd_addr = cur;
  assign rd_en = busy && !wait_rd && (cur != NIL);
  assign ctl = '{start: start, busy: busy, done: done, hit: hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      wait_rd <= 1'b0;
      done <= 1'b0;
      hit <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        wait_rd <= 1'b0;
        cur <= head;
        prev <= NIL;
        hit <= 1'b0;
      end else if (busy) begin
        if (!wait_rd) begin
          if (cur == NIL) begin
            busy <= 1'b0;
            done <= 1'b1;
            hit <= 1'b0;
          end else begin
            wait_rd <= 1'b1;
          end
        end else begin
          wait_rd <= 1'b0;
          if (rd_key == target) begin
            busy <= 1'b0;
            done <= 1'b1;
            hit <= 1'b1;
            node <= cur;
          end else begin
            prev <= cur;
            cur <= rd_next;
          end
        end
      end
    end
  end
endmodule

// ===== design/chained_hash_map.sv =====
`timescale 1ns / 1ps
// throughput: one request at a time; next request taken once the result is taken
// swap walks both chains back to back; insert from the free list reads the free
// node, then writes it; delete reads the node, relinks around it, then links it
// onto the free list; swap exchange reads the first node, writes its value to the
// second node, then the second key's value to the first. reset: bucket heads are
// swept to null after reset, taking no request meanwhile; node memory is not cleared
module chained_hash_map import chm_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  request_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output result_t  out_data
);
  localparam int PW = $clog2(ENTRIES + 1);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  state_t state, state_next;

  logic [KEY_BITS-1:0] node_key [ENTRIES];
  logic [31:0]         node_value [ENTRIES];
  logic [PW-1:0]       node_next [ENTRIES];
  logic [PW-1:0]       bucket_head [BUCKETS];

  logic [KEY_BITS-1:0] rd_key;
  logic [31:0]         rd_value;
  logic [PW-1:0]       rd_next;

  logic [PW-1:0] free_head, fresh_count, entry_count;
  logic [2:0]    op;
  logic [KEY_BITS-1:0] k1, k2;
  logic [31:0]   val, tmp;
  logic [BW-1:0] b1, b2;
  logic [PW-1:0] n1, n2, p1;
  logic          hit1;
  logic [BW-1:0] clr;
  result_t       res;

  logic          walk_start;
  logic [PW-1:0] walk_head, walk_addr, walk_node, walk_prev;
  logic [KEY_BITS-1:0] walk_target;
  logic          walk_rd;
  walk_ctl_t     wctl;

  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [KEY_BITS-1:0] mem_wkey;
  logic [31:0]   mem_wval;
  logic [PW-1:0] mem_wnext;
  logic          wr_key, wr_val, wr_next;
  logic [PW-1:0] rd_addr_mux;
  logic          rd_en_mux;
  logic [PW-1:0] alloc;

  function automatic logic [BW-1:0] bucket_of(input logic [KEY_BITS-1:0] k);
    logic [KEY_BITS+BW-1:0] r;
    r = KEY_BITS'(k) % (KEY_BITS+BW)'(BUCKETS);
    return r[BW-1:0];
  endfunction

  chm_walker #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_walk (
    .clk, .rst, .start(walk_start), .head(walk_head), .target(walk_target),
    .rd_addr(walk_addr), .rd_en(walk_rd), .rd_key, .rd_next,
    .ctl(wctl), .node(walk_node), .prev(walk_prev)
  );

  assign in_stall = (state != S_IDLE) || out_valid;
  assign out_data = res;
  assign alloc = (free_head != NIL) ? free_head : fresh_count;

  always_comb begin
    walk_start = 1'b0;
    walk_head = bucket_head[b1];
    walk_target = k1;
    if (state == S_IDLE && in_valid && !out_valid) begin
      walk_start = in_data.operation <= OP_SWAP;
      walk_head = bucket_head[bucket_of(in_data.key[KEY_BITS-1:0])];
      walk_target = in_data.key[KEY_BITS-1:0];
    end else if (state == S_LOOK1 && wctl.done && op == OP_SWAP) begin
      walk_start = 1'b1;
      walk_head = bucket_head[b2];
      walk_target = k2;
    end else begin
      walk_target = (state == S_LOOK2) ? k2 : k1;
    end
  end

  always_comb begin
    rd_addr_mux = walk_addr;
    rd_en_mux = walk_rd;
    unique case (state)
      S_RD_FREE:            begin rd_addr_mux = free_head; rd_en_mux = 1'b1; end
      S_DEL_RD, S_SWAP_RD:  begin rd_addr_mux = n1;        rd_en_mux = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en_mux) begin
      rd_key <= node_key[rd_addr_mux[AW-1:0]];
      rd_value <= node_value[rd_addr_mux[AW-1:0]];
      rd_next <= node_next[rd_addr_mux[AW-1:0]];
    end
    if (mem_we) begin
      if (wr_key) node_key[mem_waddr[AW-1:0]] <= mem_wkey;
      if (wr_val) node_value[mem_waddr[AW-1:0]] <= mem_wval;
      if (wr_next) node_next[mem_waddr[AW-1:0]] <= mem_wnext;
    end
  end

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    wr_key = 1'b0;
    wr_val = 1'b0;
    wr_next = 1'b0;
    mem_waddr = n1;
    mem_wkey = k1;
    mem_wval = val;
    mem_wnext = bucket_head[b1];
    unique case (state)
      S_CLEAR: if (clr == BW'(BUCKETS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid && !out_valid)
          state_next = (in_data.operation <= OP_SWAP) ? S_LOOK1 : S_OUT;
      end
      S_LOOK1: begin
        if (wctl.done) state_next = (op == OP_SWAP) ? S_LOOK2 : S_ACT;
      end
      S_LOOK2: if (wctl.done) state_next = S_ACT;
      S_ACT: begin
        state_next = S_OUT;
        unique case (op)
          OP_INSERT: begin
            if (!hit1 && alloc != NIL) begin
              if (free_head != NIL) state_next = S_RD_FREE;
              else begin
                mem_we = 1'b1; wr_key = 1'b1; wr_val = 1'b1; wr_next = 1'b1;
                mem_waddr = fresh_count;
              end
            end
          end
          OP_DELETE: if (hit1) state_next = S_DEL_RD;
          OP_SET: if (hit1) begin mem_we = 1'b1; wr_val = 1'b1; end
          OP_SWAP: if (hit1 && n2 != NIL && n1 != n2) state_next = S_SWAP_RD;
          default: ;
        endcase
      end
      S_RD_FREE: state_next = S_RD_FREE_W;
      S_RD_FREE_W: begin
        state_next = S_OUT;
        mem_we = 1'b1; wr_key = 1'b1; wr_val = 1'b1; wr_next = 1'b1;
        mem_waddr = free_head;
      end
      S_DEL_RD: state_next = S_DEL_RD_W;
      S_DEL_RD_W: begin
        state_next = S_DEL_LINK;
        if (p1 != NIL) begin
          mem_we = 1'b1; wr_next = 1'b1; mem_waddr = p1; mem_wnext = rd_next;
        end
      end
      S_DEL_LINK: begin
        state_next = S_OUT;
        mem_we = 1'b1; wr_next = 1'b1; mem_waddr = n1; mem_wnext = free_head;
      end
      S_SWAP_RD: state_next = S_SWAP_RD_W;
      S_SWAP_RD_W: begin
        state_next = S_SWAP_WR;
        mem_we = 1'b1; wr_val = 1'b1; mem_waddr = n2; mem_wval = rd_value;
      end
      S_SWAP_WR: begin
        state_next = S_OUT;
        mem_we = 1'b1; wr_val = 1'b1; mem_waddr = n1; mem_wval = tmp;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      free_head <= NIL;
      fresh_count <= '0;
      entry_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          bucket_head[clr] <= NIL;
          clr <= clr + BW'(1);
        end
        S_IDLE: begin
          if (in_valid && !out_valid) begin
            op <= in_data.operation;
            k1 <= in_data.key[KEY_BITS-1:0];
            k2 <= in_data.second_key[KEY_BITS-1:0];
            b1 <= bucket_of(in_data.key[KEY_BITS-1:0]);
            b2 <= bucket_of(in_data.second_key[KEY_BITS-1:0]);
            val <= in_data.value;
            res <= '{status: ST_OK, found: 1'b0, value_out: '0};
          end
        end
        S_LOOK1: if (wctl.done) begin
          hit1 <= wctl.hit;
          n1 <= wctl.hit ? walk_node : NIL;
          p1 <= walk_prev;
        end
        S_LOOK2: if (wctl.done) n2 <= wctl.hit ? walk_node : NIL;
        S_ACT: begin
          unique case (op)
            OP_INSERT: begin
              if (hit1) res.status <= ST_EXISTS;
              else if (alloc == NIL) res.status <= ST_FULL;
              else if (free_head == NIL) begin
                bucket_head[b1] <= fresh_count;
                entry_count <= entry_count + PW'(1);
                fresh_count <= fresh_count + PW'(1);
              end
            end
            OP_DELETE, OP_SET: if (!hit1) res.status <= ST_NOT_FOUND;
            OP_SEARCH: begin
              if (!hit1) res.status <= ST_NOT_FOUND;
              else begin
                res.found <= 1'b1;
                res.value_out <= rd_value;
              end
            end
            OP_SWAP: begin
              if (!hit1 || n2 == NIL) res.status <= ST_NOT_FOUND;
              // value of the second key, still held from its walk
              tmp <= rd_value;
            end
            default: ;
          endcase
        end
        S_RD_FREE_W: begin
          free_head <= rd_next;
          bucket_head[b1] <= free_head;
          entry_count <= entry_count + PW'(1);
        end
        S_DEL_RD_W: begin
          if (p1 == NIL) bucket_head[b1] <= rd_next;
          if (entry_count != '0) entry_count <= entry_count - PW'(1);
        end
        S_DEL_LINK: free_head <= n1;
        S_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

// ===== verif/chained_hash_map_checker.sv =====
`timescale 1ns / 1ps
module chained_hash_map_checker import chm_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_stall,
  input  request_t in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  result_t  out_data,
  output int       fail_count,
  output int       pending
);
  localparam int NIL = ENTRIES;

  int          head_of_bucket [BUCKETS];
  logic [31:0] pool_key [ENTRIES];
  logic [31:0] pool_value [ENTRIES];
  int          pool_next [ENTRIES];
  int          free_list;
  int          fresh_used;
  result_t     results_due [$];

  function automatic logic [31:0] key_bits(logic [31:0] k);
    if (KEY_BITS >= 32) return k;
    return k & ((32'd1 << KEY_BITS) - 1);
  endfunction

  function automatic int find_node(logic [31:0] k, output int prev);
    int n;
    prev = NIL;
    n = head_of_bucket[k % BUCKETS];
    while (n != NIL) begin
      if (pool_key[n] == k) return n;
      prev = n;
      n = pool_next[n];
    end
    return NIL;
  endfunction

  function automatic result_t apply_request(request_t rq);
    result_t r;
    logic [31:0] k, k2, t;
    int n, m, p, b;
    r = '0;
    k = key_bits(rq.key);
    k2 = key_bits(rq.second_key);
    b = k % BUCKETS;
    case (rq.operation)
      OP_INSERT: begin
        if (find_node(k, p) != NIL) r.status = ST_EXISTS;
        else begin
          n = NIL;
          if (free_list != NIL) begin
            n = free_list;
            free_list = pool_next[n];
          end else if (fresh_used < ENTRIES) begin
            n = fresh_used;
            fresh_used++;
          end
          if (n == NIL) r.status = ST_FULL;
          else begin
            pool_key[n] = k;
            pool_value[n] = rq.value;
            pool_next[n] = head_of_bucket[b];
            head_of_bucket[b] = n;
          end
        end
      end
      OP_DELETE: begin
        n = find_node(k, p);
        if (n == NIL) r.status = ST_NOT_FOUND;
        else begin
          if (p == NIL) head_of_bucket[b] = pool_next[n];
          else pool_next[p] = pool_next[n];
          pool_next[n] = free_list;
          free_list = n;
        end
      end
      OP_SEARCH: begin
        n = find_node(k, p);
        if (n == NIL) r.status = ST_NOT_FOUND;
        else begin
          r.found = 1'b1;
          r.value_out = pool_value[n];
        end
      end
      OP_SET: begin
        n = find_node(k, p);
        if (n == NIL) r.status = ST_NOT_FOUND;
        else pool_value[n] = rq.value;
      end
      OP_SWAP: begin
        n = find_node(k, p);
        m = find_node(k2, p);
        if (n == NIL || m == NIL) r.status = ST_NOT_FOUND;
        else begin
          t = pool_value[n];
          pool_value[n] = pool_value[m];
          pool_value[m] = t;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending = results_due.size();

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      for (int i = 0; i < BUCKETS; i++) head_of_bucket[i] = NIL;
      free_list = NIL;
      fresh_used = 0;
      fail_count <= 0;
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = results_due.pop_front();
          if (out_data.status !== exp_r.status || out_data.found !== exp_r.found ||
              out_data.value_out !== exp_r.value_out) begin
            $display("%0t: mismatch expected status %0d found %0d value %h, got %0d %0d %h",
                     $time, exp_r.status, exp_r.found, exp_r.value_out,
                     out_data.status, out_data.found, out_data.value_out);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) results_due.push_back(apply_request(in_data));
    end
  end
endmodule

// ===== verif/chained_hash_map_tb.sv =====
`timescale 1ns / 1ps
module chained_hash_map_tb;
  import chm_pkg::*;
  localparam int ENTRIES = 1024;
  localparam int WATCHDOG = 20000;

  logic     clk, rst;
  logic     in_valid, in_stall, out_valid, out_stall;
  request_t in_data;
  result_t  out_data;
  int       fail_count, pending, idle_cycles;
  logic     timed_out;
  logic [31:0] key_pool [16];
  logic [31:0] live_keys [$];

  chained_hash_map u_dut (.*);

  chained_hash_map_checker u_chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern
  int stall_mode;
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst) stall_mode <= 0;
    else if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end
  assign timed_out = idle_cycles >= WATCHDOG;

  task automatic send(logic [2:0] op, logic [31:0] k, logic [31:0] v, logic [31:0] k2);
    in_valid <= 1'b1;
    in_data <= '{operation: op, key: k, value: v, second_key: k2};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender();
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_key();
    if (live_keys.size() != 0 && $urandom_range(0, 2) != 0)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    return key_pool[$urandom_range(0, 15)];
  endfunction

  initial begin
    logic [2:0] op;
    logic [31:0] k;
    int burst;
    int sel;
    in_valid = 1'b0;
    in_data = '0;
    rst = 1'b1;
    for (int i = 0; i < 16; i++)
      key_pool[i] = (i < 4) ? $urandom_range(0, 7) * 16 + 3 : $urandom();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send(OP_SEARCH, 32'h0, 0, 0);
    send(OP_INSERT, 32'h0, 32'hffff_ffff, 0);
    send(OP_INSERT, 32'hffff_ffff, 32'h0, 0);
    send(OP_INSERT, 32'h10, 32'h1234_5678, 0);
    send(OP_INSERT, 32'h20, 32'h5a5a_a5a5, 0);
    send(OP_INSERT, 32'h10, 32'h1, 0);
    send(OP_SEARCH, 32'h10, 0, 0);
    send(OP_SEARCH, 32'h0, 0, 0);
    send(OP_SET, 32'h20, 32'hdead_beef, 0);
    send(OP_SET, 32'h30, 32'h1, 0);
    send(OP_SWAP, 32'h0, 0, 32'hffff_ffff);
    send(OP_SWAP, 32'h10, 0, 32'h10);
    send(OP_SWAP, 32'h10, 0, 32'h40);
    send(OP_SEARCH, 32'hffff_ffff, 0, 0);
    send(OP_DELETE, 32'h10, 0, 0);
    send(OP_DELETE, 32'h10, 0, 0);
    send(OP_DELETE, 32'h0, 0, 0);
    send(OP_SEARCH, 32'h20, 0, 0);
    send(3'd5, 32'h1, 32'h2, 32'h3);
    send(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send(OP_INSERT, 32'h50, 32'h7, 0);
    send(OP_SEARCH, 32'h50, 0, 0);

    // fill the pool to hit the full case, then drain some
    for (int i = 0; i < ENTRIES + 4; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      send(OP_INSERT, 32'h1000_0000 + i, $urandom(), 0);
    end
    for (int i = 0; i < ENTRIES; i += 32) send(OP_DELETE, 32'h1000_0000 + i, 0, 0);
    for (int i = 0; i < 8; i++) send(OP_INSERT, 32'h2000_0000 + i, $urandom(), 0);

    // random mix around a small key set
    for (int n = 0; n < 150; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++, n++) begin
        sel = $urandom_range(0, 9);
        if (sel > 4) op = (sel == 9) ? 3'($urandom_range(5, 7)) : OP_SEARCH;
        else op = 3'(sel);
        k = pick_key();
        send(op, k, $urandom(), pick_key());
        if (op == OP_INSERT) live_keys.push_back(k);
      end
      pause_sender();
    end
    in_valid <= 1'b0;
  end

  initial begin
    wait (!rst);
    @(posedge clk);
    wait (in_valid == 1'b0 && pending == 0 && u_chk.results_due.size() == 0 || timed_out);
  end

  initial begin
    int settle;
    settle = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (timed_out) begin
        $display("== FAIL ==");
        $finish;
      end
      if (!in_valid && pending == 0 && idle_cycles > 0) settle++;
      else settle = 0;
      if (settle >= 200) begin
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
      end
    end
  end
endmodule

// ===== chained_hash_map.f =====
design/chm_pkg.sv
design/chm_walker.sv
design/chained_hash_map.sv
verif/chained_hash_map_checker.sv
verif/chained_hash_map_tb.sv
